/* sv/qsh_pkg.sv */
// Shared types, constants and Q16.16 helpers for the quad-to-square homography.
// Used by qsh_div and the top module; depends on nothing.
package qsh_pkg;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [65:0] wide_t;

  localparam q16_t Q_ONE = 32'sh0001_0000;
  localparam q16_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q16_t Q_MIN = 32'sh8000_0000;
  localparam wide_t W_MAX = 66'sh7FFF_FFFF;
  localparam wide_t W_MIN = -66'sh8000_0000;

  // quotient bits of the divider: 16 integer bits, 16 fraction bits, one round bit
  localparam int DIV_BITS = 33;
  localparam int DIV_LAT  = DIV_BITS + 2;

  function automatic q16_t sat32(input wide_t p);
    if (p > W_MAX) return Q_MAX;
    if (p < W_MIN) return Q_MIN;
    return p[31:0];
  endfunction

  // round to nearest, ties away from zero, drop 16 fraction bits
  function automatic wide_t rnd_wide(input wide_t p);
    logic [65:0] mag;
    logic [65:0] r;
    mag = p[65] ? 66'(-p) : 66'(p);
    r = (mag + 66'd32768) >> 16;
    return p[65] ? -signed'(r) : signed'(r);
  endfunction

  function automatic q16_t rnd_sat(input wide_t p);
    return sat32(rnd_wide(p));
  endfunction

  function automatic q16_t qsub(input q16_t a, input q16_t b);
    return sat32(66'(a) - 66'(b));
  endfunction

  function automatic q16_t qadd(input q16_t a, input q16_t b);
    return sat32(66'(a) + 66'(b));
  endfunction

endpackage

/* sv/qsh_delay.sv */
// Enabled shift line that carries side data alongside the divider stages.
// Uses no package items.
module qsh_delay #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sh_r [0:D-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= din;
    end
  end

  for (genvar k = 1; k < D; k++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        sh_r[k] <= sh_r[k-1];
      end
    end
  end

  assign dout = sh_r[D-1];

endmodule

/* sv/qsh_div.sv */
// Pipelined Q16.16 divider, one quotient bit per stage, rounded and saturated.
// Depends on qsh_pkg for types and the stage count.
module qsh_div (
  input  logic          clk,
  input  logic          en,
  input  qsh_pkg::q16_t num,
  input  qsh_pkg::q16_t den,
  output qsh_pkg::q16_t quo
);

  localparam int NB = qsh_pkg::DIV_BITS;

  typedef struct packed {
    logic neg;
    logic ovf;
    logic zero;
  } dflg_t;

  logic [31:0]   rem_r  [0:NB];
  logic [NB-1:0] tail_r [0:NB];
  logic [NB-1:0] qb_r   [0:NB];
  logic [31:0]   uq_r   [0:NB];
  dflg_t         flg_r  [0:NB];
  qsh_pkg::q16_t quo_r;

  logic [31:0] un;
  logic [31:0] uq;
  logic [32:0] mag;

  assign un = num[31] ? (~num + 32'd1) : num;
  assign uq = den[31] ? (~den + 32'd1) : den;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]       <= {16'd0, un[31:16]};
      tail_r[0]      <= {un[15:0], 17'd0};
      qb_r[0]        <= '0;
      uq_r[0]        <= uq;
      flg_r[0].neg   <= num[31] ^ den[31];
      flg_r[0].ovf   <= {16'd0, un} >= {uq, 16'd0};
      flg_r[0].zero  <= (uq == 32'd0);
    end
  end

  for (genvar k = 1; k <= NB; k++) begin : g_stg
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem_r[k-1], tail_r[k-1][NB-1]};
    assign ge    = trial >= {1'b0, uq_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? 32'(trial - {1'b0, uq_r[k-1]}) : trial[31:0];
        tail_r[k] <= {tail_r[k-1][NB-2:0], 1'b0};
        qb_r[k]   <= {qb_r[k-1][NB-2:0], ge};
        uq_r[k]   <= uq_r[k-1];
        flg_r[k]  <= flg_r[k-1];
      end
    end
  end

  // half-up on the extra quotient bit
  assign mag = 33'((34'(qb_r[NB]) + 34'd1) >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      if (flg_r[NB].zero) begin
        quo_r <= '0;
      end else if (!flg_r[NB].neg) begin
        quo_r <= (flg_r[NB].ovf || mag > 33'h7FFF_FFFF) ? qsh_pkg::Q_MAX : mag[31:0];
      end else begin
        quo_r <= (flg_r[NB].ovf || mag >= 33'h8000_0000) ? qsh_pkg::Q_MIN
                                                           : 32'(-signed'({1'b0, mag}));
      end
    end
  end

  assign quo = quo_r;

endmodule

/* sv/quad_to_square_homography.sv */
// Quad-to-unit-square projective matrix: differences, products, divider stages.
// Depends on qsh_pkg, qsh_div and qsh_delay.
//
// One quad enters per cycle while the output is not stalled; each quad passes
// through two 35-stage dividers in series, the first for the projective terms
// u and v, the second for the nine cofactor quotients, plus eleven stages of
// capture, differences, 32x32 products and rounding. A stall at the output
// freezes the whole pipeline; nothing is dropped or repeated.
module quad_to_square_homography (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,     // affine_tolerance
  input  logic         in_tvalid,
  output logic         in_tready,
  // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // col0_x, col0_y, col0_w, col1_x, col1_y, col1_w, col2_x, col2_y, col2_w
  output logic [287:0] out_tdata,
  // singular, not_convex, affine
  output logic [2:0]   out_tuser
);

  localparam int DL  = qsh_pkg::DIV_LAT;
  localparam int LAT = 4 + DL + 6 + DL + 1;

  typedef struct packed {
    qsh_pkg::q16_t sx10, sy10, sx21, sy21, sx30, sy30;
    qsh_pkg::q16_t x0, y0, x1, y1, x3, y3;
    logic          aff;
    logic          ncv;
    logic          dz;
  } prj_t;

  typedef struct packed {
    logic sing;
    logic ncv;
    logic aff;
  } flg_t;

  logic        adv;
  logic [15:0] tol_r;
  logic [LAT:1] v_r;

  assign adv       = !v_r[LAT] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 16'd1;
      v_r   <= '0;
    end else begin
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      if (adv) begin
        v_r <= {v_r[LAT-1:1], in_tvalid};
      end
    end
  end

  // stage 1: capture corners
  qsh_pkg::q16_t cx_r [0:3];
  qsh_pkg::q16_t cy_r [0:3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        cx_r[i] <= in_tdata[64*i +: 32];
        cy_r[i] <= in_tdata[64*i+32 +: 32];
      end
    end
  end

  // stage 2: differences and affine test
  logic signed [33:0] dxw, dyw, tol_s;
  logic               aff;
  prj_t               p2_nxt, p2_r, p3_r, p4_nxt, p4_r, pd;
  qsh_pkg::q16_t      d1x2_r, d1y2_r, d2x2_r, d2y2_r, dx2_r, dy2_r;
  qsh_pkg::q16_t      ex_r [0:3];
  qsh_pkg::q16_t      ey_r [0:3];
  qsh_pkg::q16_t      fx_r [0:3];
  qsh_pkg::q16_t      fy_r [0:3];

  assign dxw   = 34'(cx_r[0]) - 34'(cx_r[1]) + 34'(cx_r[2]) - 34'(cx_r[3]);
  assign dyw   = 34'(cy_r[0]) - 34'(cy_r[1]) + 34'(cy_r[2]) - 34'(cy_r[3]);
  assign tol_s = signed'({18'd0, tol_r});
  assign aff   = (dxw < tol_s) && (dxw > -tol_s) && (dyw < tol_s) && (dyw > -tol_s);

  always_comb begin
    p2_nxt.sx10 = qsh_pkg::qsub(cx_r[1], cx_r[0]);
    p2_nxt.sy10 = qsh_pkg::qsub(cy_r[1], cy_r[0]);
    p2_nxt.sx21 = qsh_pkg::qsub(cx_r[2], cx_r[1]);
    p2_nxt.sy21 = qsh_pkg::qsub(cy_r[2], cy_r[1]);
    p2_nxt.sx30 = qsh_pkg::qsub(cx_r[3], cx_r[0]);
    p2_nxt.sy30 = qsh_pkg::qsub(cy_r[3], cy_r[0]);
    p2_nxt.x0   = cx_r[0];
    p2_nxt.y0   = cy_r[0];
    p2_nxt.x1   = cx_r[1];
    p2_nxt.y1   = cy_r[1];
    p2_nxt.x3   = cx_r[3];
    p2_nxt.y3   = cy_r[3];
    p2_nxt.aff  = aff;
    p2_nxt.ncv  = 1'b0;
    p2_nxt.dz   = 1'b0;
  end

  always_ff @(posedge clk) begin
    logic [1:0] ib, ic;
    if (adv) begin
      p2_r   <= p2_nxt;
      d1x2_r <= qsh_pkg::qsub(cx_r[1], cx_r[2]);
      d1y2_r <= qsh_pkg::qsub(cy_r[1], cy_r[2]);
      d2x2_r <= qsh_pkg::qsub(cx_r[3], cx_r[2]);
      d2y2_r <= qsh_pkg::qsub(cy_r[3], cy_r[2]);
      dx2_r  <= qsh_pkg::sat32(66'(dxw));
      dy2_r  <= qsh_pkg::sat32(66'(dyw));
      for (int i = 0; i < 4; i++) begin
        ib = 2'(i + 1);
        ic = 2'(i + 2);
        ex_r[i] <= qsh_pkg::qsub(cx_r[ib], cx_r[i]);
        ey_r[i] <= qsh_pkg::qsub(cy_r[ib], cy_r[i]);
        fx_r[i] <= qsh_pkg::qsub(cx_r[ic], cx_r[i]);
        fy_r[i] <= qsh_pkg::qsub(cy_r[ic], cy_r[i]);
      end
    end
  end

  // stage 3: products
  qsh_pkg::prod_t pda_r, pdb_r, pua_r, pub_r, pva_r, pvb_r;
  qsh_pkg::prod_t pca_r [0:3];
  qsh_pkg::prod_t pcb_r [0:3];

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_r  <= p2_r;
      pda_r <= d1x2_r * d2y2_r;
      pdb_r <= d2x2_r * d1y2_r;
      pua_r <= dx2_r * d2y2_r;
      pub_r <= dy2_r * d2x2_r;
      pva_r <= dy2_r * d1x2_r;
      pvb_r <= dx2_r * d1y2_r;
      for (int i = 0; i < 4; i++) begin
        pca_r[i] <= ex_r[i] * fy_r[i];
        pcb_r[i] <= ey_r[i] * fx_r[i];
      end
    end
  end

  // stage 4: round the crosses, convexity sign
  qsh_pkg::q16_t den4, nu4_r, nv4_r, den4_r;
  logic          ncv;

  assign den4 = qsh_pkg::rnd_sat(66'(pda_r) - 66'(pdb_r));

  always_comb begin
    ncv = 1'b0;
    for (int i = 0; i < 4; i++) begin
      ncv = ncv | (66'(pca_r[i]) - 66'(pcb_r[i]) < 66'sd0);
    end
  end

  always_comb begin
    p4_nxt     = p3_r;
    p4_nxt.ncv = ncv;
    p4_nxt.dz  = (den4 == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_r     <= p4_nxt;
      den4_r   <= den4;
      nu4_r    <= qsh_pkg::rnd_sat(66'(pua_r) - 66'(pub_r));
      nv4_r    <= qsh_pkg::rnd_sat(66'(pva_r) - 66'(pvb_r));
    end
  end

  qsh_pkg::q16_t u_q, v_q;

  qsh_div u_div_u (.clk(clk), .en(adv), .num(nu4_r), .den(den4_r), .quo(u_q));
  qsh_div u_div_v (.clk(clk), .en(adv), .num(nv4_r), .den(den4_r), .quo(v_q));

  qsh_delay #(.W($bits(prj_t)), .D(DL)) u_dly_prj (
    .clk(clk), .en(adv), .din(p4_r), .dout(pd)
  );

  // P1: projective products
  qsh_pkg::prod_t pux_r, puy_r, pvx_r, pvy_r;
  qsh_pkg::q16_t  u5_r, v5_r;
  prj_t           p5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pux_r <= u_q * pd.x1;
      puy_r <= u_q * pd.y1;
      pvx_r <= v_q * pd.x3;
      pvy_r <= v_q * pd.y3;
      u5_r  <= u_q;
      v5_r  <= v_q;
      p5_r  <= pd;
    end
  end

  // P2: square-to-quad matrix
  qsh_pkg::q16_t m_r [0:8];
  flg_t          f6_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0] <= p5_r.aff ? p5_r.sx10 : qsh_pkg::qadd(p5_r.sx10, qsh_pkg::rnd_sat(66'(pux_r)));
      m_r[1] <= p5_r.aff ? p5_r.sy10 : qsh_pkg::qadd(p5_r.sy10, qsh_pkg::rnd_sat(66'(puy_r)));
      m_r[2] <= p5_r.aff ? '0 : u5_r;
      m_r[3] <= p5_r.aff ? p5_r.sx21 : qsh_pkg::qadd(p5_r.sx30, qsh_pkg::rnd_sat(66'(pvx_r)));
      m_r[4] <= p5_r.aff ? p5_r.sy21 : qsh_pkg::qadd(p5_r.sy30, qsh_pkg::rnd_sat(66'(pvy_r)));
      m_r[5] <= p5_r.aff ? '0 : v5_r;
      m_r[6] <= p5_r.x0;
      m_r[7] <= p5_r.y0;
      m_r[8] <= qsh_pkg::Q_ONE;
      f6_r.sing <= !p5_r.aff && p5_r.dz;
      f6_r.ncv  <= p5_r.ncv;
      f6_r.aff  <= p5_r.aff;
    end
  end

  // C1: cofactor products, entry i is a*b - c*d
  qsh_pkg::q16_t  ca [0:8];
  qsh_pkg::q16_t  cb [0:8];
  qsh_pkg::q16_t  cc [0:8];
  qsh_pkg::q16_t  cd [0:8];
  qsh_pkg::prod_t cpa_r [0:8];
  qsh_pkg::prod_t cpb_r [0:8];
  qsh_pkg::q16_t  m7_r [0:2];
  flg_t           f7_r;

  always_comb begin
    ca[0] = m_r[4]; cb[0] = m_r[8]; cc[0] = m_r[7]; cd[0] = m_r[5];
    ca[1] = m_r[7]; cb[1] = m_r[2]; cc[1] = m_r[1]; cd[1] = m_r[8];
    ca[2] = m_r[1]; cb[2] = m_r[5]; cc[2] = m_r[4]; cd[2] = m_r[2];
    ca[3] = m_r[6]; cb[3] = m_r[5]; cc[3] = m_r[3]; cd[3] = m_r[8];
    ca[4] = m_r[0]; cb[4] = m_r[8]; cc[4] = m_r[6]; cd[4] = m_r[2];
    ca[5] = m_r[3]; cb[5] = m_r[2]; cc[5] = m_r[0]; cd[5] = m_r[5];
    ca[6] = m_r[3]; cb[6] = m_r[7]; cc[6] = m_r[6]; cd[6] = m_r[4];
    ca[7] = m_r[6]; cb[7] = m_r[1]; cc[7] = m_r[0]; cd[7] = m_r[7];
    ca[8] = m_r[0]; cb[8] = m_r[4]; cc[8] = m_r[3]; cd[8] = m_r[1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        cpa_r[i] <= ca[i] * cb[i];
        cpb_r[i] <= cc[i] * cd[i];
      end
      for (int i = 0; i < 3; i++) begin
        m7_r[i] <= m_r[i];
      end
      f7_r <= f6_r;
    end
  end

  // C2: cofactors
  qsh_pkg::q16_t cof8_r [0:8];
  qsh_pkg::q16_t m8_r [0:2];
  flg_t          f8_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        cof8_r[i] <= qsh_pkg::rnd_sat(66'(cpa_r[i]) - 66'(cpb_r[i]));
      end
      m8_r <= m7_r;
      f8_r <= f7_r;
    end
  end

  // C3: determinant products over the first column cofactors
  qsh_pkg::prod_t dp_r [0:2];
  qsh_pkg::q16_t  cof9_r [0:8];
  flg_t           f9_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dp_r[0] <= m8_r[0] * cof8_r[0];
      dp_r[1] <= m8_r[1] * cof8_r[3];
      dp_r[2] <= m8_r[2] * cof8_r[6];
      cof9_r  <= cof8_r;
      f9_r    <= f8_r;
    end
  end

  // C4: determinant
  qsh_pkg::q16_t det, det_r;
  qsh_pkg::q16_t cof10_r [0:8];
  flg_t          f10_nxt, f10_r, fo;

  assign det = qsh_pkg::sat32(qsh_pkg::rnd_wide(66'(dp_r[0])) +
                              qsh_pkg::rnd_wide(66'(dp_r[1])) +
                              qsh_pkg::rnd_wide(66'(dp_r[2])));

  always_comb begin
    f10_nxt      = f9_r;
    f10_nxt.sing = f9_r.sing || (det == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det_r        <= det;
      cof10_r      <= cof9_r;
      f10_r        <= f10_nxt;
    end
  end

  qsh_pkg::q16_t quo [0:8];

  for (genvar g = 0; g < 9; g++) begin : g_div
    qsh_div u_div (.clk(clk), .en(adv), .num(cof10_r[g]), .den(det_r), .quo(quo[g]));
  end

  qsh_delay #(.W($bits(flg_t)), .D(DL)) u_dly_flg (
    .clk(clk), .en(adv), .din(f10_r), .dout(fo)
  );

  // output register: zero matrix when singular
  qsh_pkg::q16_t r_r [0:8];
  flg_t          fr_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        r_r[i] <= fo.sing ? '0 : quo[i];
      end
      fr_r <= fo;
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      out_tdata[32*i +: 32] = r_r[i];
    end
  end

  assign out_tvalid = v_r[LAT];
  assign out_tuser  = {fr_r.aff, fr_r.ncv, fr_r.sing};

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("singular item with nonzero matrix");

  a_aff_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata[95:64] == '0 && out_tdata[191:160] == '0)
    else $error("affine item with projective terms");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
